/* hdl/tgarle_pkg.sv */
// Shared types and constants for the TGA run-length pixel decoder.
`timescale 1ns / 1ps
`default_nettype none

package tgarle_pkg;

  // Pixels per output word, capped at the four pixel ports
  localparam int LANES = 4;
  localparam int MAX_PACKET = 128;
  localparam int BEAT_WIDTH = (LANES < 4) ? LANES : 4;
  localparam logic [2:0] BEAT_W = 3'(BEAT_WIDTH);

  // Configuration register indexes
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_PIXEL_TOTAL = 1'b1;

  // Reset values of the configuration registers
  localparam logic [2:0] CHANNEL_COUNT_RST = 3'd4;
  localparam logic [31:0] PIXEL_TOTAL_RST = 32'd1;

  // Stream parse phase
  typedef enum logic {
    PH_PACKET,
    PH_PIXEL
  } phase_t;

  // Controller states
  typedef enum logic {
    ST_INPUT,
    ST_EMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_byte;
    logic load_word;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_emit;
    logic out_free;
    logic word_last;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hdl/tgarle_ctrl.sv */
// Controller state machine: byte intake and output word sequencing.
`timescale 1ns / 1ps
`default_nettype none

module tgarle_ctrl
  import tgarle_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dp_sts_t   sts,
  output ctrl_cmd_t      cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INPUT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INPUT: begin
        if (in_valid && sts.go_emit) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free && sts.word_last) begin
          state_next = ST_INPUT;
        end
      end
      default: state_next = ST_INPUT;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.take_byte = 1'b0;
    cmd.load_word = 1'b0;
    unique case (state)
      ST_INPUT: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
      end
      ST_EMIT: begin
        cmd.load_word = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/tgarle_dp.sv */
// Datapath: configuration, packet state, pixel assembly and output word register.
`timescale 1ns / 1ps
`default_nettype none

module tgarle_dp
  import tgarle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [7:0]  data_byte,
  input  wire logic        stream_end,
  input  wire ctrl_cmd_t   cmd,
  output dp_sts_t          sts,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [31:0]      pixel_0,
  output logic [31:0]      pixel_1,
  output logic [31:0]      pixel_2,
  output logic [31:0]      pixel_3,
  output logic [2:0]       pixel_valid,
  output logic             beat_last,
  output logic             image_done,
  output logic             short_stream
);

  logic [2:0]  channel_count;
  logic [31:0] pixel_total;

  phase_t      phase;
  logic        packet_is_repeat;
  logic [7:0]  packet_left;
  logic [1:0]  byte_index;
  logic [31:0] pixel_assembly;
  logic [31:0] pixels_written;
  logic [7:0]  reps_left;
  logic        end_seen;

  logic [2:0]  ch_eff;
  logic        pixel_complete;
  logic [31:0] assembly_next;
  logic [31:0] remaining;
  logic        rem_wide;
  logic [2:0]  cap_total;
  logic [2:0]  cap_reps;
  logic [2:0]  word_count;
  logic        word_done;
  logic        word_last;
  logic [7:0]  packet_left_next;
  logic        out_free;
  logic [3:0][31:0] lane_px;

  // Channel count clamp: 0 acts as 1, above 4 acts as 4
  always_comb begin
    if (channel_count == 3'd0) begin
      ch_eff = 3'd1;
    end else if (channel_count > 3'd4) begin
      ch_eff = 3'd4;
    end else begin
      ch_eff = channel_count;
    end
  end

  // Byte intake decode
  assign pixel_complete = (phase == PH_PIXEL) && (({1'b0, byte_index} + 3'd1) >= ch_eff);
  assign assembly_next  = pixel_assembly | ({24'b0, data_byte} << {byte_index, 3'b000});

  // Word size: bounded by lanes, pixels left to repeat and pixels left in the image.
  // A zero difference means the count wrapped, i.e. 2^32 pixels left.
  assign remaining = pixel_total - pixels_written;
  assign rem_wide  = (remaining == 32'd0) || (remaining >= {29'b0, BEAT_W});
  assign cap_total = rem_wide ? BEAT_W : remaining[2:0];
  assign cap_reps  = (reps_left >= {5'b0, BEAT_W}) ? BEAT_W : reps_left[2:0];
  assign word_count = (cap_reps < cap_total) ? cap_reps : cap_total;
  assign word_done  = (remaining != 32'd0) && ({29'b0, word_count} == remaining);
  assign word_last  = word_done || (reps_left == {5'b0, word_count});
  assign packet_left_next = packet_left - {5'b0, word_count};

  assign out_free = !out_valid || out_ready;

  assign sts.go_emit   = pixel_complete || stream_end;
  assign sts.out_free  = out_free;
  assign sts.word_last = word_last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RST;
      pixel_total   <= PIXEL_TOTAL_RST;
    end else if (cfg_write) begin
      if (cfg_index == REG_CHANNEL_COUNT) begin
        channel_count <= cfg_data[2:0];
      end else begin
        pixel_total <= cfg_data;
      end
    end
  end

  // Packet and image state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_PACKET;
      packet_is_repeat <= 1'b0;
      packet_left      <= 8'd0;
      byte_index       <= 2'd0;
      pixel_assembly   <= 32'd0;
      pixels_written   <= 32'd0;
      reps_left        <= 8'd0;
      end_seen         <= 1'b0;
    end else if (cmd.take_byte) begin
      end_seen <= stream_end;
      if (phase == PH_PACKET) begin
        // Raw and repeat counts both come out as low seven bits plus one
        packet_is_repeat <= data_byte[7];
        packet_left      <= {1'b0, data_byte[6:0]} + 8'd1;
        phase            <= PH_PIXEL;
        byte_index       <= 2'd0;
        pixel_assembly   <= 32'd0;
        reps_left        <= 8'd0;
      end else begin
        pixel_assembly <= assembly_next;
        if (pixel_complete) begin
          byte_index <= 2'd0;
          reps_left  <= packet_is_repeat ? packet_left : 8'd1;
        end else begin
          byte_index <= byte_index + 2'd1;
          reps_left  <= 8'd0;
        end
      end
    end else if (cmd.load_word) begin
      reps_left      <= reps_left - {5'b0, word_count};
      packet_left    <= packet_left_next;
      pixels_written <= pixels_written + {29'b0, word_count};
      if (word_last) begin
        pixel_assembly <= 32'd0;
        if (word_done || end_seen) begin
          // Image finished or abandoned: wait for a new image
          phase            <= PH_PACKET;
          packet_is_repeat <= 1'b0;
          packet_left      <= 8'd0;
          byte_index       <= 2'd0;
          pixels_written   <= 32'd0;
        end else if (packet_left_next == 8'd0) begin
          phase <= PH_PACKET;
        end
      end
    end
  end

  // Lane fill, unused lanes zero
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      lane_px[j] = (3'(j) < word_count) ? pixel_assembly : 32'd0;
    end
  end

  // Output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_word) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      pixel_0      <= lane_px[0];
      pixel_1      <= lane_px[1];
      pixel_2      <= lane_px[2];
      pixel_3      <= lane_px[3];
      pixel_valid  <= word_count;
      beat_last    <= word_last;
      image_done   <= word_last && word_done;
      short_stream <= word_last && end_seen && !word_done;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_valid <= BEAT_W))
    else $error("output word holds more pixels than lanes");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (image_done || short_stream)) |-> beat_last)
    else $error("image end flag on a word that is not the last of its byte");

  a_done_not_short: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(image_done && short_stream))
    else $error("image done and short stream on the same word");

  a_empty_is_short: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (pixel_valid == 3'd0)) |-> short_stream)
    else $error("empty output word without stream error");

  a_packet_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXEL) |-> (packet_left != 8'd0))
    else $error("pixel phase with an exhausted packet");
`endif

endmodule

`default_nettype wire

/* hdl/tga_rle_pixel_decoder_unit.sv */
// Top level of the TGA run-length pixel decoder.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a TGA run-length pixel stream taken one byte per word on the input
// channel and delivers pixels in output words of up to four, first file byte
// in the low bits of each pixel. A byte that neither finishes a pixel nor
// carries stream_end only updates the parse state; a stream_end byte that
// finishes no pixel also causes an empty word. A byte that finishes a pixel
// causes one output word per up to four pixels (ceil(n/4) words for n
// pixels, so up to 32 words for a full 128-pixel repeat packet), paced by
// the output word register and the controller's emit state, and stalled by
// back-pressure on the output. Input is held off while a byte's words are
// being emitted. Decoding stops at pixel_total pixels (image_done on that
// word); a stream_end before that sets short_stream on the last word, or on
// an empty word when the byte gave no pixel. Configure channel_count (index
// 0) and pixel_total (index 1) only while the block is idle.
module tga_rle_pixel_decoder_unit
  import tgarle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        stream_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      pixel_0,
  output logic [31:0]      pixel_1,
  output logic [31:0]      pixel_2,
  output logic [31:0]      pixel_3,
  output logic [2:0]       pixel_valid,
  output logic             beat_last,
  output logic             image_done,
  output logic             short_stream
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  tgarle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tgarle_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .stream_end   (stream_end),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .pixel_0      (pixel_0),
    .pixel_1      (pixel_1),
    .pixel_2      (pixel_2),
    .pixel_3      (pixel_3),
    .pixel_valid  (pixel_valid),
    .beat_last    (beat_last),
    .image_done   (image_done),
    .short_stream (short_stream)
  );

endmodule

`default_nettype wire
